>>> rtl/core/klc_pkg.sv
// Shared types, constants and the keyword match function of the keyword language classifier.
`default_nettype none
package klc_pkg;

	localparam longint unsigned MAX_TEXT_BYTES = 64'd65535;
	localparam int unsigned WIN_LEN = 5;
	localparam int unsigned N_LANG = 5;
	localparam int unsigned N_WORDS = 42;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	typedef enum logic [2:0] {
		LANG_EN  = 3'd0,
		LANG_ES  = 3'd1,
		LANG_FR  = 3'd2,
		LANG_DE  = 3'd3,
		LANG_IT  = 3'd4,
		LANG_PT  = 3'd5,
		LANG_MUL = 3'd6
	} lang_t;

	localparam logic [N_LANG-1:0] L_ES = 5'b00001;
	localparam logic [N_LANG-1:0] L_FR = 5'b00010;
	localparam logic [N_LANG-1:0] L_DE = 5'b00100;
	localparam logic [N_LANG-1:0] L_IT = 5'b01000;
	localparam logic [N_LANG-1:0] L_PT = 5'b10000;

	typedef logic [WIN_LEN-1:0][7:0] window_t;

	// A keyword is right-aligned: its last letter sits in the lowest byte.
	typedef struct packed {
		logic [31:0]       word;
		logic [2:0]        len;
		logic [N_LANG-1:0] langs;
	} kw_t;

	localparam kw_t KW_TABLE [N_WORDS] = '{
		'{32'("el"), 3'd2, L_ES}, '{32'("la"), 3'd2, L_ES | L_FR},
		'{32'("de"), 3'd2, L_ES | L_PT}, '{32'("que"), 3'd3, L_ES | L_PT},
		'{32'("es"), 3'd2, L_ES}, '{32'("con"), 3'd3, L_ES | L_IT},
		'{32'("y"), 3'd1, L_ES}, '{32'("en"), 3'd2, L_ES},
		'{32'("un"), 3'd2, L_ES | L_FR | L_IT}, '{32'("una"), 3'd3, L_ES | L_IT},
		'{32'("le"), 3'd2, L_FR}, '{32'("et"), 3'd2, L_FR},
		'{32'("ce"), 3'd2, L_FR}, '{32'("qui"), 3'd3, L_FR},
		'{32'("avec"), 3'd4, L_FR}, '{32'("est"), 3'd3, L_FR},
		'{32'("dans"), 3'd4, L_FR}, '{32'("pour"), 3'd4, L_FR},
		'{32'("und"), 3'd3, L_DE}, '{32'("der"), 3'd3, L_DE},
		'{32'("die"), 3'd3, L_DE}, '{32'("das"), 3'd3, L_DE},
		'{32'("mit"), 3'd3, L_DE}, '{32'("ist"), 3'd3, L_DE},
		'{32'("ein"), 3'd3, L_DE}, '{32'("eine"), 3'd4, L_DE},
		'{32'("auf"), 3'd3, L_DE}, '{32'("von"), 3'd3, L_DE},
		'{32'("il"), 3'd2, L_IT}, '{32'("che"), 3'd3, L_IT},
		'{32'("per"), 3'd3, L_IT}, '{32'("sono"), 3'd4, L_IT},
		'{32'("e"), 3'd1, L_IT | L_PT}, '{32'("in"), 3'd2, L_IT},
		'{32'("non"), 3'd3, L_IT},
		'{32'("o"), 3'd1, L_PT}, '{32'("a"), 3'd1, L_PT},
		'{32'("para"), 3'd4, L_PT}, '{32'("com"), 3'd3, L_PT},
		'{32'("em"), 3'd2, L_PT}, '{32'("um"), 3'd2, L_PT},
		'{32'("uma"), 3'd3, L_PT}
	};

	// Window index 4 holds the newest byte. Each keyword needs a space just before it.
	function automatic logic [N_LANG-1:0] match_hits(input window_t win);
		logic [N_LANG-1:0] hits;
		logic              ok;
		int                first;
		hits = '0;
		for (int k = 0; k < N_WORDS; k++) begin
			first = WIN_LEN - 1 - int'(KW_TABLE[k].len);
			ok = (win[first] == SPACE_CHAR);
			for (int p = 0; p < WIN_LEN; p++) begin
				if (p > first) begin
					ok = ok & (win[p] == KW_TABLE[k].word[8*(WIN_LEN-1-p) +: 8]);
				end
			end
			if (ok) begin
				hits = hits | KW_TABLE[k].langs;
			end
		end
		return hits;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/klc_cell.sv
// One byte cell of the recent-byte window chain.
`default_nettype none
module klc_cell (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       shift,
	input  wire logic       clr,
	input  wire logic [7:0] din,
	output logic      [7:0] dout
);
	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clr) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
endmodule
`default_nettype wire

>>> rtl/core/klc_sat_counter.sv
// Saturating counter with a synchronous clear and a look-ahead of its next value.
`default_nettype none
module klc_sat_counter #(
	parameter longint unsigned MAX_VAL = 64'd65535,
	parameter int unsigned     CNT_W   = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             inc,
	input  wire logic             clr,
	output logic      [CNT_W-1:0] cnt_nxt
);
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		cnt_nxt = cnt_q;
		if (inc && (cnt_q < CNT_W'(MAX_VAL))) begin
			cnt_nxt = cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/keyword_language_classifier_unit.sv
// Top level of the keyword language classifier.
// The input stream carries one text byte per transfer: tdata is the byte, tuser says
// whether the byte is present, and tlast ends the text and asks for a language code.
// A transfer with tuser low and tlast high classifies the bytes seen so far.
// The output stream carries one code per text in tdata[2:0]:
// 0 en, 1 es, 2 fr, 3 de, 4 it, 5 pt, 6 mul.
// Bytes go through a chain of five byte cells; keyword matching, hit flags and the
// two saturating counters update in the cycle of the transfer, so one byte is taken
// every cycle while s_axis_tready is high. The tlast transfer snapshots the final
// state into a holding stage and clears the live state at once, so the next text can
// follow in the next cycle. With a free output register, the holding stage passes the
// code on into the output register, where m_axis_tvalid rises; it is held in the
// output register until taken. While the receiver stalls, the holding stage and the
// output register keep one code each; once both are full, s_axis_tready drops and
// every transfer waits. Reset clears the window, flags, counters and both valid flags.
`default_nettype none
module keyword_language_classifier_unit #(
	parameter longint unsigned MAX_TEXT_BYTES = klc_pkg::MAX_TEXT_BYTES
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
	input  wire logic       s_axis_tuser,   // [0] has_byte
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic      [7:0] m_axis_tdata    // [2:0] language, [7:3] zero
);
	import klc_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_TEXT_BYTES + 64'd1);
	localparam int unsigned PROD_W = CNT_W + 4;

	logic              acc, byte_en, last_en, out_adv;
	logic [7:0]        lc_byte;
	logic              is_space;
	window_t           win;
	logic [N_LANG-1:0] hits_q, hits_nxt;
	logic [CNT_W-1:0]  bc_nxt, na_nxt;

	logic              v_s1;
	logic [N_LANG-1:0] hits_s1;
	logic [CNT_W-1:0]  bc_s1, na_s1;

	logic              m_valid_q;
	lang_t             code_q, code;
	logic [PROD_W-1:0] na_x10;

	assign acc = s_axis_tvalid & s_axis_tready;
	assign byte_en = acc & s_axis_tuser;
	assign last_en = acc & s_axis_tlast;
	assign out_adv = ~m_valid_q | m_axis_tready;
	assign s_axis_tready = ~v_s1 | out_adv;

	always_comb begin
		lc_byte = s_axis_tdata;
		if ((s_axis_tdata >= 8'h41) && (s_axis_tdata <= 8'h5A)) begin
			lc_byte = s_axis_tdata + 8'd32;
		end
	end
	assign is_space = (lc_byte == SPACE_CHAR);

	for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
		logic [7:0] din;
		if (i == WIN_LEN - 1) begin : g_head
			assign din = lc_byte;
		end else begin : g_body
			assign din = win[i+1];
		end
		klc_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (byte_en),
			.clr   (last_en),
			.din   (din),
			.dout  (win[i])
		);
	end

	always_comb begin
		hits_nxt = hits_q;
		if (byte_en && is_space) begin
			hits_nxt = hits_q | match_hits(win);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
		end else if (last_en) begin
			hits_q <= '0;
		end else begin
			hits_q <= hits_nxt;
		end
	end

	klc_sat_counter #(.MAX_VAL(MAX_TEXT_BYTES), .CNT_W(CNT_W)) u_byte_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.inc    (byte_en),
		.clr    (last_en),
		.cnt_nxt(bc_nxt)
	);

	klc_sat_counter #(.MAX_VAL(MAX_TEXT_BYTES), .CNT_W(CNT_W)) u_non_ascii_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.inc    (byte_en & lc_byte[7]),
		.clr    (last_en),
		.cnt_nxt(na_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (last_en) begin
			v_s1 <= 1'b1;
		end else if (out_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_en) begin
			hits_s1 <= hits_nxt;
			bc_s1 <= bc_nxt;
			na_s1 <= na_nxt;
		end
	end

	assign na_x10 = {na_s1, 3'b000} + {1'b0, na_s1, 2'b00} + PROD_W'(0) + {2'b00, na_s1, 1'b0}
		- {1'b0, na_s1, 2'b00};

	always_comb begin
		priority if (hits_s1[0]) begin
			code = LANG_ES;
		end else if (hits_s1[1]) begin
			code = LANG_FR;
		end else if (hits_s1[2]) begin
			code = LANG_DE;
		end else if (hits_s1[3]) begin
			code = LANG_IT;
		end else if (hits_s1[4]) begin
			code = LANG_PT;
		end else if (na_x10 > PROD_W'(bc_s1)) begin
			code = LANG_MUL;
		end else begin
			code = LANG_EN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_adv) begin
			m_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && v_s1) begin
			code_q <= code;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {5'b00000, code_q};
endmodule
`default_nettype wire

>>> rtl/core/klc_checker.sv
// Port-level assertions for the keyword language classifier, bound to the top level.
`default_nettype none
module klc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic       s_axis_tlast,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);
	import klc_pkg::*;

	logic last_xfer;
	assign last_xfer = s_axis_tvalid & s_axis_tready & s_axis_tlast;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transfer changed while stalled");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0) && (m_axis_tdata[2:0] <= LANG_MUL))
		else $error("language code out of range");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		last_xfer |=> ##1 m_axis_tvalid)
		else $error("no result after end of text");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !$past(last_xfer) |-> s_axis_tready)
		else $error("input stalled with nothing pending");
endmodule

bind keyword_language_classifier_unit klc_checker u_klc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
